[rtl/core/tdoa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the TDOA multilateration row builder.
// Used by tdoa_div and tdoa_multilateration_matrix_builder; no dependencies.
package tdoa_pkg;

    localparam int RECEIVER_COUNT = 5;
    localparam int DIVIDEND_W     = 128;
    localparam int DIVISOR_W      = 33;

    // Request from the sequencer to the shared divider.
    typedef struct packed {
        logic                  start;
        logic                  neg;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

endpackage

[rtl/core/tdoa_multilateration_matrix_builder.sv]
`timescale 1ns / 1ps
// Top level of the TDOA multilateration row builder: input capture, sequencer,
// shared multiplier and output register. Depends on tdoa_pkg and tdoa_div.
//
// Usage:
//   s_axis carries receiver words in sets of five. Word 0 gives the reference
//   arrival time (its position is ignored); words 1..4 give positions and
//   arrival times. After the fifth word the block emits three rows on m_axis
//   (receivers 2, 3, 4 against receiver 1), the third marked with tlast.
//   i_cfg_we/i_cfg_wdata write the wave speed; write it only while idle.
// Sequencing:
//   Words 0..3 are taken whenever they are offered. The fifth word starts the row
//   work: per row the squares and the speed product on the shared 32x32 multiplier,
//   then 12 divisions one after another on the shared bit-serial divider; the rows
//   are worked in turn. A row whose time difference is zero skips the work and goes
//   to the output register with the fault flag set.
//   s_axis_tready is low from the fifth word until the last row is taken.
// Reset: synchronous, active low; clears the word count, the reference time,
//   the sequencer and sets the wave speed to 1500 m/s.
// Stall: a row waits in the output register while m_axis_tready is low; the
//   sequencer holds until it is taken.
module tdoa_multilateration_matrix_builder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // pos_x, pos_y, pos_z, arrival_time
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [263:0] m_axis_tdata,  // row_index, coef_x, coef_y, coef_z, rhs_value, pad
    output logic         m_axis_tuser,  // divide_fault
    output logic         m_axis_tlast,  // last_row
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata
);
    import tdoa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // Sequencer steps: multiplies first, then divisions.
    localparam logic [4:0] ST_SQ_X1 = 5'd0;
    localparam logic [4:0] ST_SQ_Y1 = 5'd1;
    localparam logic [4:0] ST_SQ_Z1 = 5'd2;
    localparam logic [4:0] ST_SQ_XI = 5'd3;
    localparam logic [4:0] ST_SQ_YI = 5'd4;
    localparam logic [4:0] ST_SQ_ZI = 5'd5;
    localparam logic [4:0] ST_WD_LO = 5'd6;
    localparam logic [4:0] ST_WD_HI = 5'd7;
    localparam logic [4:0] ST_Q1_X  = 5'd8;
    localparam logic [4:0] ST_QI_X  = 5'd9;
    localparam logic [4:0] ST_CF_X  = 5'd10;
    localparam logic [4:0] ST_Q1_Y  = 5'd11;
    localparam logic [4:0] ST_QI_Y  = 5'd12;
    localparam logic [4:0] ST_CF_Y  = 5'd13;
    localparam logic [4:0] ST_Q1_Z  = 5'd14;
    localparam logic [4:0] ST_QI_Z  = 5'd15;
    localparam logic [4:0] ST_CF_Z  = 5'd16;
    localparam logic [4:0] ST_S1    = 5'd17;
    localparam logic [4:0] ST_SI    = 5'd18;
    localparam logic [4:0] ST_SC    = 5'd19;

    localparam logic [2:0]  LAST_WORD = 3'(RECEIVER_COUNT - 1);
    localparam logic [1:0]  LAST_ROW  = 2'(RECEIVER_COUNT - 3);
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [32:0] abs33(input logic [32:0] v);
        abs33 = v[32] ? (~v + 33'd1) : v;
    endfunction

    t_state       r_state;
    logic [2:0]   r_cnt;
    logic [31:0]  r_ref_time;
    logic [31:0]  r_wave_speed;
    logic [31:0]  r_w;
    logic [31:0]  r_x1, r_y1, r_z1;
    logic [32:0]  r_t1;
    logic [31:0]  r_xs [3];
    logic [31:0]  r_ys [3];
    logic [31:0]  r_zs [3];
    logic [32:0]  r_ts [3];
    logic [1:0]   r_row;
    logic [4:0]   r_step;
    logic         r_phase;
    logic [63:0]  r_prod;
    logic [63:0]  r_d1, r_di, r_pl;
    logic [33:0]  r_phi;
    logic [63:0]  r_qa, r_qb;
    logic [63:0]  r_cx, r_cy, r_cz, r_rhs;
    logic         r_fault;

    logic         w_in_acc, w_out_acc;
    logic [32:0]  w_td;
    logic [31:0]  w_xi, w_yi, w_zi;
    logic [32:0]  w_ti;
    logic [33:0]  w_dt;
    logic [33:0]  w_dm;
    logic [31:0]  w_ma, w_mb;
    logic [31:0]  w_p1, w_pi;
    logic         w_qge;
    logic [63:0]  w_qdm;
    t_div_req     w_req;
    logic         w_div_done;
    logic [63:0]  w_quot;
    logic [65:0]  w_wdm;
    logic [63:0]  w_first;
    logic [63:0]  w_sum;
    logic [63:0]  w_rhs;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_td      = {1'b0, s_axis_tdata[127:96]} - {1'b0, r_ref_time};

    assign w_xi = r_xs[r_row];
    assign w_yi = r_ys[r_row];
    assign w_zi = r_zs[r_row];
    assign w_ti = r_ts[r_row];
    assign w_dt = {w_ti[32], w_ti} - {r_t1[32], r_t1};
    assign w_dm = w_dt[33] ? (~w_dt + 34'd1) : w_dt;

    // Shared multiplier operands.
    always_comb begin
        w_ma = r_w;
        w_mb = w_dm[31:0];
        case (r_step)
            ST_SQ_X1: begin w_ma = abs32(r_x1); w_mb = abs32(r_x1); end
            ST_SQ_Y1: begin w_ma = abs32(r_y1); w_mb = abs32(r_y1); end
            ST_SQ_Z1: begin w_ma = abs32(r_z1); w_mb = abs32(r_z1); end
            ST_SQ_XI: begin w_ma = abs32(w_xi); w_mb = abs32(w_xi); end
            ST_SQ_YI: begin w_ma = abs32(w_yi); w_mb = abs32(w_yi); end
            ST_SQ_ZI: begin w_ma = abs32(w_zi); w_mb = abs32(w_zi); end
            ST_WD_HI: begin w_ma = r_w; w_mb = {30'd0, w_dm[33:32]}; end
            default:  begin w_ma = r_w; w_mb = w_dm[31:0]; end
        endcase
    end

    // Axis selection for the position quotients.
    always_comb begin
        case (r_step)
            ST_Q1_Y, ST_QI_Y: begin w_p1 = r_y1; w_pi = w_yi; end
            ST_Q1_Z, ST_QI_Z: begin w_p1 = r_z1; w_pi = w_zi; end
            default:          begin w_p1 = r_x1; w_pi = w_xi; end
        endcase
    end

    assign w_qge = $signed(r_qa) >= $signed(r_qb);
    assign w_qdm = w_qge ? (r_qa - r_qb) : (r_qb - r_qa);

    // Divider request for the current step.
    always_comb begin
        w_req.start = (r_state == S_DIV) && !r_phase;
        case (r_step)
            ST_Q1_X, ST_Q1_Y, ST_Q1_Z: begin
                w_req.neg      = w_p1[31] ^ r_t1[32];
                w_req.dividend = {56'd0, abs32(w_p1), 40'd0};
                w_req.divisor  = abs33(r_t1);
            end
            ST_QI_X, ST_QI_Y, ST_QI_Z: begin
                w_req.neg      = w_pi[31] ^ w_ti[32];
                w_req.dividend = {56'd0, abs32(w_pi), 40'd0};
                w_req.divisor  = abs33(w_ti);
            end
            ST_S1: begin
                w_req.neg      = r_t1[32];
                w_req.dividend = {40'd0, r_d1, 24'd0};
                w_req.divisor  = abs33(r_t1);
            end
            ST_SI: begin
                w_req.neg      = w_ti[32];
                w_req.dividend = {40'd0, r_di, 24'd0};
                w_req.divisor  = abs33(w_ti);
            end
            ST_SC: begin
                w_req.neg      = !w_qge;
                w_req.dividend = {48'd0, w_qdm, 16'd0};
                w_req.divisor  = {1'b0, r_w};
            end
            default: begin
                w_req.neg      = !w_qge;
                w_req.dividend = {47'd0, w_qdm, 17'd0};
                w_req.divisor  = {1'b0, r_w};
            end
        endcase
    end

    tdoa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Speed term W*(Ti-T1)/2^8 never saturates; add the distance term with saturation.
    assign w_wdm   = {r_phi, 32'd0} + {2'd0, r_pl};
    assign w_first = w_dt[33] ? (~{6'd0, w_wdm[65:8]} + 64'd1) : {6'd0, w_wdm[65:8]};
    assign w_sum   = w_first + w_quot;
    always_comb begin
        if (((w_first ^ w_quot) & SMIN) == '0 && ((w_sum ^ w_first) & SMIN) != '0) begin
            w_rhs = w_first[63] ? SMIN : SMAX;
        end else begin
            w_rhs = w_sum;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_speed <= 32'd98304000;
        end else if (i_cfg_we) begin
            r_wave_speed <= i_cfg_wdata;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_ref_time <= '0;
            r_row      <= '0;
            r_step     <= '0;
            r_phase    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (r_cnt == 3'd0) begin
                            r_ref_time <= s_axis_tdata[127:96];
                        end
                        if (r_cnt == LAST_WORD) begin
                            r_cnt   <= '0;
                            r_row   <= '0;
                            r_step  <= ST_SQ_X1;
                            r_phase <= 1'b0;
                            r_state <= S_MUL;
                        end else begin
                            r_cnt <= r_cnt + 3'd1;
                        end
                    end
                end
                S_MUL: begin
                    if (!r_phase && r_step == ST_SQ_X1 && (r_t1 == '0 || w_ti == '0)) begin
                        r_state <= S_OUT;
                    end else if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        r_step  <= r_step + 5'd1;
                        if (r_step == ST_WD_HI) begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else if (w_div_done) begin
                        r_phase <= 1'b0;
                        if (r_step == ST_SC) begin
                            r_state <= S_OUT;
                        end else begin
                            r_step <= r_step + 5'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_acc) begin
                        if (r_row == LAST_ROW) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + 2'd1;
                            r_step  <= ST_SQ_X1;
                            r_phase <= 1'b0;
                            r_state <= S_MUL;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Receiver capture; receiver 1 is kept apart from receivers 2..4.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc) begin
            if (r_cnt == 3'd1) begin
                r_x1 <= s_axis_tdata[31:0];
                r_y1 <= s_axis_tdata[63:32];
                r_z1 <= s_axis_tdata[95:64];
                r_t1 <= w_td;
            end else if (r_cnt != 3'd0) begin
                r_xs[2'(r_cnt - 3'd2)] <= s_axis_tdata[31:0];
                r_ys[2'(r_cnt - 3'd2)] <= s_axis_tdata[63:32];
                r_zs[2'(r_cnt - 3'd2)] <= s_axis_tdata[95:64];
                r_ts[2'(r_cnt - 3'd2)] <= w_td;
            end
            if (r_cnt == LAST_WORD) begin
                r_w <= (r_wave_speed == '0) ? 32'd1 : r_wave_speed;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            if (!r_phase) begin
                r_prod <= w_ma * w_mb;
                if (r_step == ST_SQ_X1) begin
                    r_d1    <= '0;
                    r_di    <= '0;
                    r_fault <= (r_t1 == '0 || w_ti == '0);
                    r_cx    <= '0;
                    r_cy    <= '0;
                    r_cz    <= '0;
                    r_rhs   <= '0;
                end
            end else begin
                case (r_step)
                    ST_SQ_X1, ST_SQ_Y1, ST_SQ_Z1: r_d1 <= r_d1 + r_prod;
                    ST_SQ_XI, ST_SQ_YI, ST_SQ_ZI: r_di <= r_di + r_prod;
                    ST_WD_LO: r_pl  <= r_prod;
                    default:  r_phi <= r_prod[33:0];
                endcase
            end
        end
        if (r_state == S_DIV && r_phase && w_div_done) begin
            case (r_step)
                ST_Q1_X, ST_Q1_Y, ST_Q1_Z, ST_S1: r_qa <= w_quot;
                ST_QI_X, ST_QI_Y, ST_QI_Z, ST_SI: r_qb <= w_quot;
                ST_CF_X: r_cx  <= w_quot;
                ST_CF_Y: r_cy  <= w_quot;
                ST_CF_Z: r_cz  <= w_quot;
                default: r_rhs <= w_rhs;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {6'd0, r_rhs, r_cz, r_cy, r_cx, r_row};
    assign m_axis_tuser  = r_fault;
    assign m_axis_tlast  = (r_row == LAST_ROW);

endmodule

[rtl/core/tdoa_div.sv]
`timescale 1ns / 1ps
// Shared restoring divider: 128-bit magnitude over 33-bit divisor, one bit a cycle,
// signed 64-bit saturated result. Depends on tdoa_pkg.
module tdoa_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tdoa_pkg::t_div_req i_req,
    output logic               o_done,
    output logic [63:0]        o_quot
);
    import tdoa_pkg::*;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    logic                  r_busy;
    logic                  r_done;
    logic [6:0]            r_cnt;
    logic [DIVIDEND_W-1:0] r_q;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_den;
    logic                  r_neg;
    logic [DIVISOR_W:0]    w_rem2;
    logic                  w_ge;
    logic [DIVISOR_W:0]    w_sub;

    assign w_rem2 = {r_rem, r_q[DIVIDEND_W-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    assign w_sub  = w_rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_q   <= {r_q[DIVIDEND_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DIVISOR_W-1:0] : w_rem2[DIVISOR_W-1:0];
        end
    end

    // Saturate the 128-bit quotient to signed 64 bits.
    always_comb begin
        if (!r_neg) begin
            o_quot = (r_q[127:64] != '0 || r_q[63:0] > SMAX) ? SMAX : r_q[63:0];
        end else if (r_q[127:64] != '0 || r_q[63:0] > SMIN) begin
            o_quot = SMIN;
        end else begin
            o_quot = ~r_q[63:0] + 64'd1;
        end
    end

    assign o_done = r_done;

endmodule

[rtl/core/tdoa_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the TDOA row builder, bound to the top level.
// No package dependency.
module tdoa_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [263:0] m_axis_tdata,
    input logic         m_axis_tuser,
    input logic         m_axis_tlast
);

    // Input and output never open at once: one set is worked at a time.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a row is pending");

    // A stalled row holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled row changed");

    // The marked row is the third.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == 2'd2)
        else $error("last row with wrong index");

    // A faulted row carries zeros.
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[257:2] == '0)
        else $error("faulted row not zero");

endmodule

bind tdoa_multilateration_matrix_builder tdoa_chk u_tdoa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[tb/tdoa_multilateration_matrix_builder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the TDOA multilateration row builder.
// Depends on tdoa_pkg and tdoa_multilateration_matrix_builder; drives receiver
// sets, predicts every row in fixed point and checks each row on m_axis.
module tdoa_multilateration_matrix_builder_tb;
    import tdoa_pkg::*;

    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;
    localparam logic [31:0] SPEED_AT_RESET = 32'd98304000;
    localparam int          LAST_ROW_INDEX = 2;

    typedef struct {
        logic [1:0]  row;
        logic [63:0] cx;
        logic [63:0] cy;
        logic [63:0] cz;
        logic [63:0] rhs;
        logic        fault;
        logic        last;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;     // pos_x, pos_y, pos_z, arrival_time
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [263:0] m_axis_tdata;          // row_index, coef_x, coef_y, coef_z, rhs_value, pad
    logic         m_axis_tuser;          // divide_fault
    logic         m_axis_tlast;          // last_row
    logic         i_cfg_we = 1'b0;
    logic [31:0]  i_cfg_wdata = '0;

    // Predictor state: mirrors the block's word count, reference and stores.
    logic [31:0]  speed_reg = SPEED_AT_RESET;
    int           words_in_set = 0;
    logic [31:0]  ref_arrival = '0;
    longint       tdiff [RECEIVER_COUNT-1];
    int           rx_x [RECEIVER_COUNT-1];
    int           rx_y [RECEIVER_COUNT-1];
    int           rx_z [RECEIVER_COUNT-1];

    t_row         rows_pending[$];
    int           mismatches = 0;
    bit           steady = 1'b0;  // when set, neither side idles

    tdoa_multilateration_matrix_builder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // ---------------- fixed-point helpers ----------------

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Clamp a sign/magnitude value into signed 64 bits.
    function automatic logic [63:0] clamp_signed(bit neg, logic [127:0] m);
        if (!neg) begin
            return (m > {64'b0, SAT_POS}) ? SAT_POS : m[63:0];
        end
        return (m > {64'b0, SAT_NEG}) ? SAT_NEG : (~m[63:0] + 64'd1);
    endfunction

    function automatic logic [63:0] divide_clamped(bit neg, logic [127:0] num,
                                                   logic [63:0] den);
        return clamp_signed(neg, num / {64'b0, den});
    endfunction

    // Exact a - b as sign and magnitude (magnitude always fits 64 bits).
    function automatic logic [63:0] diff_magnitude(longint a, longint b, output bit neg);
        neg = (a < b);
        return neg ? (64'(b) - 64'(a)) : (64'(a) - 64'(b));
    endfunction

    function automatic longint slowness_term(int p, longint t);
        logic [127:0] num;
        num = {96'b0, 32'(magnitude(longint'(p)))} << 40;
        return longint'(divide_clamped((p < 0) != (t < 0), num, magnitude(t)));
    endfunction

    function automatic longint range_term(int k, longint t);
        logic [63:0] a, b, c, d;
        a = magnitude(longint'(rx_x[k]));
        b = magnitude(longint'(rx_y[k]));
        c = magnitude(longint'(rx_z[k]));
        d = a * a + b * b + c * c;
        return longint'(divide_clamped(t < 0, {64'b0, d} << 24, magnitude(t)));
    endfunction

    function automatic logic [63:0] row_coefficient(int p1, int pi, longint t1, longint ti,
                                                    logic [63:0] w);
        bit          neg;
        logic [63:0] m;
        m = diff_magnitude(slowness_term(p1, t1), slowness_term(pi, ti), neg);
        return divide_clamped(neg, {64'b0, m} << 17, w);
    endfunction

    function automatic logic [63:0] row_rhs(int k, longint t1, longint ti, logic [63:0] w);
        bit           neg;
        logic [127:0] prod;
        logic [63:0]  m, first, second, s;
        prod   = {64'b0, w} * {64'b0, magnitude(ti - t1)};
        first  = clamp_signed(ti < t1, prod >> 8);
        m      = diff_magnitude(range_term(0, t1), range_term(k, ti), neg);
        second = divide_clamped(neg, {64'b0, m} << 16, w);
        s      = first + second;
        if (first[63] == second[63] && s[63] != first[63]) begin
            return first[63] ? SAT_NEG : SAT_POS;
        end
        return s;
    endfunction

    // Advance the predictor by one accepted receiver word.
    task automatic predict_word(logic [127:0] word);
        logic [31:0] arrival;
        logic [63:0] w;
        t_row        r;
        int          k;
        arrival = word[127:96];
        if (words_in_set == 0) begin
            ref_arrival  = arrival;
            words_in_set = 1;
            return;
        end
        k = words_in_set - 1;
        tdiff[k] = longint'({32'b0, arrival}) - longint'({32'b0, ref_arrival});
        rx_x[k]  = int'(word[31:0]);
        rx_y[k]  = int'(word[63:32]);
        rx_z[k]  = int'(word[95:64]);
        if (words_in_set < RECEIVER_COUNT - 1) begin
            words_in_set++;
            return;
        end
        words_in_set = 0;
        // A speed of zero acts as one.
        w = (speed_reg == 0) ? 64'd1 : {32'b0, speed_reg};
        for (int i = 1; i < RECEIVER_COUNT - 1; i++) begin
            r.row   = 2'(i - 1);
            r.fault = (tdiff[0] == 0) || (tdiff[i] == 0);
            r.last  = (i - 1 == LAST_ROW_INDEX);
            if (r.fault) begin
                r.cx = '0; r.cy = '0; r.cz = '0; r.rhs = '0;
            end else begin
                r.cx  = row_coefficient(rx_x[0], rx_x[i], tdiff[0], tdiff[i], w);
                r.cy  = row_coefficient(rx_y[0], rx_y[i], tdiff[0], tdiff[i], w);
                r.cz  = row_coefficient(rx_z[0], rx_z[i], tdiff[0], tdiff[i], w);
                r.rhs = row_rhs(i, tdiff[0], tdiff[i], w);
            end
            rows_pending.push_back(r);
        end
    endtask

    // ---------------- stimulus ----------------

    // Send one receiver word, idling first at random; hold tvalid high after.
    task automatic send_word(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] t);
        if (!steady && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t, z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_word({t, z, y, x});
    endtask

    task automatic wait_for_rows();
        s_axis_tvalid <= 1'b0;
        while (rows_pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write the speed only with the block idle.
    task automatic set_speed(logic [31:0] v);
        wait_for_rows();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        speed_reg   = v;
    endtask

    function automatic logic [31:0] random_position();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return 32'($signed(16'($urandom())) <<< 16);
            default: return 32'(int'($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    // One random set: mostly distinct arrivals, sometimes a repeated reference.
    task automatic send_random_set();
        logic [31:0] t0, t;
        t0 = $urandom();
        send_word(random_position(), random_position(), random_position(), t0);
        for (int i = 1; i < RECEIVER_COUNT; i++) begin
            t = ($urandom_range(19) == 0) ? t0 :
                ($urandom_range(1) ? $urandom() : t0 + 32'($urandom_range(200000)) - 32'd100000);
            send_word(random_position(), random_position(), random_position(), t);
        end
    endtask

    task automatic test_default_speed();
        // Plain geometry with distinct, positive time differences.
        send_word(32'h0, 32'h0, 32'h0, 32'h0100_0000);
        send_word(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0100_1000);
        send_word(32'hFFFF_0000, 32'h0005_0000, 32'h0000_8000, 32'h0100_3000);
        send_word(32'h0010_0000, 32'hFFF0_0000, 32'h0001_0000, 32'h0100_0800);
        send_word(32'h0, 32'h0, 32'h0, 32'h0100_2000);
    endtask

    task automatic test_zero_time_difference();
        // Receiver 1 arrives with the reference: every row faults.
        send_word(32'h1234_5678, 32'h0, 32'h0, 32'h0000_4000);
        send_word(32'h0001_0000, 32'h0, 32'h0, 32'h0000_4000);
        send_word(32'h0002_0000, 32'h0, 32'h0, 32'h0000_5000);
        send_word(32'h0003_0000, 32'h0, 32'h0, 32'h0000_6000);
        send_word(32'h0004_0000, 32'h0, 32'h0, 32'h0000_7000);
        // Only receiver 3 coincides with the reference: the middle row faults.
        send_word(32'h0, 32'h0, 32'h0, 32'h0000_4000);
        send_word(32'h0001_0000, 32'h0, 32'h0, 32'h0000_4100);
        send_word(32'h0002_0000, 32'h0, 32'h0, 32'h0000_3000);
        send_word(32'h0003_0000, 32'h0, 32'h0, 32'h0000_4000);
        send_word(32'h0004_0000, 32'h0, 32'h0, 32'h0000_9000);
    endtask

    task automatic test_field_extremes();
        // Full-scale positions, earliest and latest arrivals, tiny differences.
        set_speed(32'd1);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001);
        send_word(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
        // Speed of zero behaves as one; the top speed drives the coefficients small.
        set_speed(32'd0);
        send_random_set();
        set_speed(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFE);
        send_word(32'h0, 32'h0, 32'h0, 32'h0000_0001);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678);
    endtask

    task automatic test_random_sets();
        logic [31:0] speeds [4];
        speeds[0] = SPEED_AT_RESET;
        speeds[1] = $urandom();
        speeds[2] = 32'($urandom_range(65535, 1));
        speeds[3] = 32'hFFFF_FFFF;
        for (int p = 0; p < 4; p++) begin
            set_speed(speeds[p]);
            // Phase 1 runs with no idling on either side.
            steady = (p == 1);
            repeat (19) send_random_set();
        end
        steady = 1'b0;
    endtask

    // Receiver stalls: outside the steady phase, ready drops about a quarter of the time.
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 24);
    end

    // Check each accepted row against the oldest predicted row.
    always @(posedge i_clk) begin
        t_row e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rows_pending.size() == 0) begin
                $display("%t unexpected row: expected none, actual row %0d",
                         $time, m_axis_tdata[1:0]);
                mismatches++;
            end else begin
                e = rows_pending.pop_front();
                if (m_axis_tdata[1:0] !== e.row) begin
                    $display("%t row_index: expected %0d actual %0d",
                             $time, e.row, m_axis_tdata[1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[65:2] !== e.cx) begin
                    $display("%t coef_x: expected %h actual %h", $time, e.cx, m_axis_tdata[65:2]);
                    mismatches++;
                end
                if (m_axis_tdata[129:66] !== e.cy) begin
                    $display("%t coef_y: expected %h actual %h",
                             $time, e.cy, m_axis_tdata[129:66]);
                    mismatches++;
                end
                if (m_axis_tdata[193:130] !== e.cz) begin
                    $display("%t coef_z: expected %h actual %h",
                             $time, e.cz, m_axis_tdata[193:130]);
                    mismatches++;
                end
                if (m_axis_tdata[257:194] !== e.rhs) begin
                    $display("%t rhs_value: expected %h actual %h",
                             $time, e.rhs, m_axis_tdata[257:194]);
                    mismatches++;
                end
                if (m_axis_tuser !== e.fault) begin
                    $display("%t divide_fault: expected %b actual %b",
                             $time, e.fault, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tlast !== e.last) begin
                    $display("%t last_row: expected %b actual %b", $time, e.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_speed();
        test_zero_time_difference();
        test_field_extremes();
        test_random_sets();
        wait_for_rows();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Timeout well beyond the 82 sets with stalls.
    initial begin
        #36_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
rtl/core/tdoa_pkg.sv
rtl/core/tdoa_div.sv
rtl/core/tdoa_multilateration_matrix_builder.sv
rtl/core/tdoa_chk.sv
tb/tdoa_multilateration_matrix_builder_tb.sv
